// File: sv/drrip_streaming_bypass_replacement_core_macros.svh
// assertion macros shared by the replacement core
`ifndef DRRIP_STREAMING_BYPASS_REPLACEMENT_CORE_MACROS_SVH
`define DRRIP_STREAMING_BYPASS_REPLACEMENT_CORE_MACROS_SVH

// property checked on every clock edge outside reset
`define DSBR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define DSBR_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: sv/dsbr_pkg.sv
`default_nettype none

package dsbr_pkg;

    localparam int SET_COUNT        = 2048;
    localparam int WAY_COUNT        = 16;
    localparam int LEADER_SET_COUNT = 64;
    localparam int LEADER_SPACING   = SET_COUNT / LEADER_SET_COUNT;

    localparam int SET_W  = 11;
    localparam int LINE_W = 58;
    localparam int WAY_W  = 4;
    localparam int DRAW_W = 5;
    localparam int RRV_W  = 2;
    localparam int RUN_W  = 2;
    localparam int WIN_W  = 4;
    localparam int SEL_W  = 10;

    // slave tdata layout
    localparam int IN_SET_LO   = 0;
    localparam int IN_LINE_LO  = IN_SET_LO + SET_W;
    localparam int IN_WAY_LO   = IN_LINE_LO + LINE_W;
    localparam int IN_DRAW_LO  = IN_WAY_LO + WAY_W;
    localparam int IN_FIELDS_W = IN_DRAW_LO + DRAW_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    // master tdata layout
    localparam int OUT_FIELDS_W = WAY_W + RRV_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [RRV_W-1:0] RRV_FAR      = 2'd3;
    localparam logic [RRV_W-1:0] RRV_LONG     = 2'd2;
    localparam logic [RRV_W-1:0] RRIP_NEAR    = 2'd0;
    localparam logic [RUN_W-1:0] RUN_MAX      = 2'd3;
    localparam logic [WIN_W-1:0] WIN_RESET    = 4'd8;
    localparam logic [SEL_W-1:0] SEL_MAX      = 10'd1023;
    localparam logic [SEL_W-1:0] SEL_MID      = 10'd512;

    typedef enum logic [1:0] {
        KIND_SRRIP,
        KIND_BRRIP,
        KIND_FOLLOWER
    } leader_kind_t;

    typedef struct packed {
        logic [WAY_COUNT*RRV_W-1:0] rrv;
        logic [LINE_W-1:0]          last_line;
        logic [RUN_W-1:0]           run;
        logic                       flag;
        logic [WIN_W-1:0]           win;
    } set_rec_t;

    localparam set_rec_t REC_RESET = '{
        rrv:       {WAY_COUNT{RRV_FAR}},
        last_line: '0,
        run:       '0,
        flag:      1'b0,
        win:       '0
    };

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
    } ctrl_sts_t;

    function automatic leader_kind_t leader_kind(input logic [SET_W-1:0] s);
        leader_kind_t k;
        if ((s % LEADER_SPACING) != 0)
            k = KIND_FOLLOWER;
        else if ((s / LEADER_SPACING) >= LEADER_SET_COUNT)
            k = KIND_FOLLOWER;
        else if ((s / LEADER_SPACING) < (LEADER_SET_COUNT / 2))
            k = KIND_SRRIP;
        else
            k = KIND_BRRIP;
        return k;
    endfunction

endpackage

`default_nettype wire

// File: sv/dsbr_ctrl.sv
`default_nettype none
`include "drrip_streaming_bypass_replacement_core_macros.svh"

module dsbr_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output dsbr_pkg::ctrl_cmd_t  cmd,
    input  dsbr_pkg::ctrl_sts_t  sts
);
    import dsbr_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_CALC  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign s_tready     = (state_reg == ST_IDLE);
    assign m_tvalid     = out_valid_reg;
    assign out_free     = !out_valid_reg || m_tready;
    assign cmd.clear_wr = (state_reg == ST_CLEAR);
    assign cmd.accept   = s_tvalid && s_tready;
    assign cmd.commit   = (state_reg == ST_CALC) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (cmd.accept)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (cmd.commit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `DSBR_NEVER(a_no_take_in_clear, (state_reg == ST_CLEAR) && s_tready, "input ready during clear")
    `DSBR_ASSERT(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready, "second item taken early")
    `DSBR_ASSERT(a_commit_shows, cmd.commit |=> m_tvalid, "committed result not presented")

endmodule

`default_nettype wire

// File: sv/dsbr_datapath.sv
`default_nettype none

module dsbr_datapath (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire [dsbr_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  wire                                 s_tuser,
    input  wire                                 cfg_valid,
    input  wire [dsbr_pkg::WIN_W-1:0]           cfg_data,
    input  dsbr_pkg::ctrl_cmd_t                 cmd,
    output dsbr_pkg::ctrl_sts_t                 sts,
    output logic [dsbr_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tuser
);
    import dsbr_pkg::*;

    // per-set state memory
    set_rec_t rec_mem [SET_COUNT];
    set_rec_t rd_reg;

    logic [SET_W-1:0]  clear_addr_reg;
    logic [WIN_W-1:0]  win_cfg_reg;
    logic [SEL_W-1:0]  sel_reg, sel_next;

    logic [SET_W-1:0]  set_reg;
    logic [LINE_W-1:0] line_reg;
    logic [LINE_W:0]   line_inc_reg;
    logic              hit_reg;
    logic [WAY_W-1:0]  hway_reg;
    logic [DRAW_W-1:0] draw_reg;

    logic [WAY_W-1:0]  way_out_reg;
    logic [RRV_W-1:0]  ins_out_reg;
    logic              byp_out_reg;

    logic [LINE_W:0]   prev_inc;
    logic [RRV_W-1:0]  rv   [WAY_COUNT];
    logic [RRV_W-1:0]  aged [WAY_COUNT];
    logic [RRV_W-1:0]  age;
    logic              any_max, any_two, any_one;
    logic [WAY_W-1:0]  victim;
    logic [WAY_W-1:0]  chosen;
    logic              unit;
    logic [RUN_W-1:0]  run_n;
    logic              flag_n;
    logic [WIN_W-1:0]  win_n, win_f;
    logic              bypass;
    logic [RRV_W-1:0]  ins;
    leader_kind_t      kind;
    logic [WAY_COUNT*RRV_W-1:0] rrv_new;
    set_rec_t          rec_new;

    logic              mem_we;
    logic [SET_W-1:0]  mem_waddr;
    set_rec_t          mem_wdata;

    // victim search: age by the gap to the top value, take the lowest way at max
    always_comb
    begin
        any_max = 1'b0;
        any_two = 1'b0;
        any_one = 1'b0;
        for (int w = 0; w < WAY_COUNT; w++)
        begin
            rv[w]   = rd_reg.rrv[w*RRV_W +: RRV_W];
            any_max = any_max | (rv[w] == RRV_FAR);
            any_two = any_two | (rv[w] == RRV_LONG);
            any_one = any_one | (rv[w] == 2'd1);
        end
        if (any_max)
            age = 2'd0;
        else if (any_two)
            age = 2'd1;
        else if (any_one)
            age = 2'd2;
        else
            age = 2'd3;
        for (int w = 0; w < WAY_COUNT; w++)
            aged[w] = rv[w] + age;
        victim = '0;
        for (int w = WAY_COUNT - 1; w >= 0; w--)
            if (aged[w] == RRV_FAR)
                victim = WAY_W'(w);
    end

    // unit-stride stream tracking
    always_comb
    begin
        prev_inc = {1'b0, rd_reg.last_line} + (LINE_W+1)'(1);
        unit = (rd_reg.last_line != '0) &&
               (({1'b0, line_reg} == prev_inc) || ({1'b0, rd_reg.last_line} == line_inc_reg));
        if (unit)
        begin
            run_n  = (rd_reg.run == RUN_MAX) ? RUN_MAX : rd_reg.run + 2'd1;
            flag_n = rd_reg.flag;
            win_n  = rd_reg.win;
            if ((run_n == RUN_MAX) && !rd_reg.flag)
            begin
                flag_n = 1'b1;
                win_n  = win_cfg_reg;
            end
        end
        else
        begin
            run_n  = '0;
            flag_n = 1'b0;
            win_n  = '0;
        end
        win_f = (flag_n && (win_n != '0)) ? win_n - 4'd1 : win_n;
    end

    // insertion value and record update
    always_comb
    begin
        kind   = leader_kind(set_reg);
        bypass = !hit_reg && flag_n && (win_f != '0);
        if (hit_reg)
            ins = RRIP_NEAR;
        else if (bypass)
            ins = RRV_FAR;
        else if ((kind == KIND_SRRIP) || ((kind == KIND_FOLLOWER) && (sel_reg >= SEL_MID)))
            ins = RRV_LONG;
        else
            ins = (draw_reg == '0) ? RRV_LONG : RRV_FAR;
        chosen = hit_reg ? hway_reg : victim;
        for (int w = 0; w < WAY_COUNT; w++)
        begin
            if (WAY_W'(w) == chosen)
                rrv_new[w*RRV_W +: RRV_W] = ins;
            else
                rrv_new[w*RRV_W +: RRV_W] = hit_reg ? rv[w] : aged[w];
        end
        rec_new.rrv       = rrv_new;
        rec_new.last_line = line_reg;
        rec_new.run       = run_n;
        rec_new.flag      = flag_n;
        rec_new.win       = win_f;
    end

    // policy selector moves on leader hits only
    always_comb
    begin
        sel_next = sel_reg;
        if (cmd.commit && hit_reg)
        begin
            if ((kind == KIND_SRRIP) && (sel_reg != SEL_MAX))
                sel_next = sel_reg + 10'd1;
            else if ((kind == KIND_BRRIP) && (sel_reg != '0))
                sel_next = sel_reg - 10'd1;
        end
    end

    assign mem_we         = cmd.clear_wr || cmd.commit;
    assign mem_waddr      = cmd.clear_wr ? clear_addr_reg : set_reg;
    assign mem_wdata      = cmd.clear_wr ? REC_RESET : rec_new;
    assign sts.clear_last = (clear_addr_reg == SET_W'(SET_COUNT - 1));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            rec_mem[mem_waddr] <= mem_wdata;
        if (cmd.accept)
            rd_reg <= rec_mem[s_tdata[IN_SET_LO +: SET_W]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            set_reg      <= s_tdata[IN_SET_LO +: SET_W];
            line_reg     <= s_tdata[IN_LINE_LO +: LINE_W];
            line_inc_reg <= {1'b0, s_tdata[IN_LINE_LO +: LINE_W]} + (LINE_W+1)'(1);
            hit_reg      <= s_tuser;
            hway_reg     <= s_tdata[IN_WAY_LO +: WAY_W];
            draw_reg     <= s_tdata[IN_DRAW_LO +: DRAW_W];
        end
        if (cmd.commit)
        begin
            way_out_reg <= chosen;
            ins_out_reg <= ins;
            byp_out_reg <= bypass;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
            win_cfg_reg    <= WIN_RESET;
            sel_reg        <= SEL_MID;
        end
        else
        begin
            if (cmd.clear_wr)
                clear_addr_reg <= clear_addr_reg + SET_W'(1);
            if (cfg_valid)
                win_cfg_reg <= cfg_data;
            sel_reg <= sel_next;
        end
    end

    assign m_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, ins_out_reg, way_out_reg};
    assign m_tuser = byp_out_reg;

endmodule

`default_nettype wire

// File: sv/drrip_streaming_bypass_replacement_core.sv
// channel   dir  signals                          payload
// s_*       in   s_tvalid s_tready s_tdata s_tuser  one cache access
// m_*       out  m_tvalid m_tready m_tdata m_tuser  chosen way and insertion value
// cfg_*     in   cfg_valid cfg_ready cfg_data       stream window length
//
// an access reads the set record from the per-set state memory at the transfer edge;
// at its commit edge it writes the record back and loads the result register,
// and no new access is taken until the previous one has committed
// after reset a clearing pass writes all 2048 set records, one per cycle,
// with s_tready low; configuration transfers are taken during it
// a result waiting on m_tready does not block the next transfer in; that access
// holds in its compute cycle until the result register frees
`default_nettype none

module drrip_streaming_bypass_replacement_core (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // set_index[10:0], line_address[68:11], hit_way[72:69], random_draw[77:73]
    input  wire [dsbr_pkg::IN_TDATA_W-1:0]      s_tdata,
    // is_hit[0]
    input  wire                                 s_tuser,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // chosen_way[3:0], inserted_value[5:4]
    output logic [dsbr_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // bypass_active[0]
    output logic                                m_tuser,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    // stream_window[3:0]
    input  wire [dsbr_pkg::WIN_W-1:0]           cfg_data
);
    import dsbr_pkg::*;

    // command and status between controller and datapath
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // the window register is a plain flop, always writable
    assign cfg_ready = 1'b1;

    // sequencer: clearing pass, accept, compute and commit
    dsbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // set memory, victim search, stream detector, selector and result register
    dsbr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
